@@ design/slab_pkg.sv @@
package slab_pkg;

    localparam int LIN_W  = 17;
    localparam int V_W    = 18;
    localparam int R_W    = 18;
    localparam int LIN2_W = 24;

    localparam int unsigned LAB_EPS  = 580;
    localparam int unsigned LAB_OFS  = 9039;
    localparam int unsigned LIN_MUL  = 7787;
    localparam int unsigned LIN_ADD  = 500;
    localparam int unsigned RECIP    = 8589935;
    localparam int          RECIP_SH = 33;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic        [14:0] lightness;
        logic signed [15:0] green_red;
        logic signed [15:0] blue_yellow;
    } lab_t;

    typedef logic [255:0][LIN_W-1:0] lin_table_t;

    function automatic lin_table_t lin_table();
        lin_table_t      tab;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned r;
        longint unsigned cand;
        longint unsigned p;
        longint unsigned c;
        tab = '0;
        for (int ci = 0; ci < 256; ci++)
        begin
            c = longint'(ci);
            if (c * 64'd100000 <= 64'd1031475)
            begin
                tab[ci] = LIN_W'((c * 64'd655360 + 64'd16473) / 64'd32946);
            end
            else
            begin
                t  = ((64'd1000 * c + 64'd14025) * 64'd65536 + 64'd134512) / 64'd269025;
                t2 = (t * t + 64'd32768) >> 16;
                r  = 64'd0;
                for (int bt = 16; bt >= 0; bt--)
                begin
                    cand = r | (64'd1 << bt);
                    p = cand;
                    for (int i = 0; i < 4; i++)
                    begin
                        p = (p * cand) >> 16;
                    end
                    if (p <= t2)
                    begin
                        r = cand;
                    end
                end
                tab[ci] = LIN_W'((t2 * r + 64'd32768) >> 16);
            end
        end
        return tab;
    endfunction

    localparam lin_table_t LIN_TABLE = lin_table();

    localparam logic [16:0] KXR = 17'((64'd41240 * 64'd65536 + 64'd47523) / 64'd95047);
    localparam logic [16:0] KXG = 17'((64'd35760 * 64'd65536 + 64'd47523) / 64'd95047);
    localparam logic [16:0] KXB = 17'((64'd18050 * 64'd65536 + 64'd47523) / 64'd95047);
    localparam logic [16:0] KYR = 17'((64'd2126 * 64'd65536 + 64'd5000) / 64'd10000);
    localparam logic [16:0] KYG = 17'((64'd7152 * 64'd65536 + 64'd5000) / 64'd10000);
    localparam logic [16:0] KYB = 17'((64'd722 * 64'd65536 + 64'd5000) / 64'd10000);
    localparam logic [16:0] KZR = 17'((64'd1930 * 64'd65536 + 64'd54441) / 64'd108883);
    localparam logic [16:0] KZG = 17'((64'd11920 * 64'd65536 + 64'd54441) / 64'd108883);
    localparam logic [16:0] KZB = 17'((64'd95050 * 64'd65536 + 64'd54441) / 64'd108883);

    function automatic logic [16:0] mat_coef(input int row, input int col);
        logic [16:0] k;
        unique case (row * 3 + col)
            0:       k = KXR;
            1:       k = KXG;
            2:       k = KXB;
            3:       k = KYR;
            4:       k = KYG;
            5:       k = KYB;
            6:       k = KZR;
            7:       k = KZG;
            8:       k = KZB;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

@@ design/slab_xyz.sv @@
module slab_xyz (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  slab_pkg::pixel_t                           in_pix,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [2:0][slab_pkg::V_W-1:0]              out_v
);

    localparam int NS = 3;
    localparam int P_W = 2 * slab_pkg::LIN_W;

    logic [NS-1:0]                        valid_reg;
    logic [NS-1:0]                        stage_en;
    logic [2:0][slab_pkg::LIN_W-1:0]      lin_reg, lin_next;
    logic [2:0][2:0][P_W-1:0]             prod_reg, prod_next;
    logic [2:0][slab_pkg::V_W-1:0]        v_reg, v_next;

    always_comb
    begin
        stage_en[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[NS-1];
    assign out_v     = v_reg;

    always_comb
    begin
        lin_next[0] = slab_pkg::LIN_TABLE[in_pix.red];
        lin_next[1] = slab_pkg::LIN_TABLE[in_pix.green];
        lin_next[2] = slab_pkg::LIN_TABLE[in_pix.blue];
    end

    always_comb
    begin
        for (int row = 0; row < 3; row++)
        begin
            for (int col = 0; col < 3; col++)
            begin
                prod_next[row][col] = P_W'(slab_pkg::mat_coef(row, col)) * P_W'(lin_reg[col]);
            end
        end
    end

    always_comb
    begin
        logic [P_W+1:0] acc;
        for (int row = 0; row < 3; row++)
        begin
            acc = (P_W+2)'(prod_reg[row][0]) + (P_W+2)'(prod_reg[row][1])
                + (P_W+2)'(prod_reg[row][2]) + (P_W+2)'(32768);
            v_next[row] = acc[16 +: slab_pkg::V_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (stage_en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            lin_reg <= lin_next;
        end
        if (stage_en[1])
        begin
            prod_reg <= prod_next;
        end
        if (stage_en[2])
        begin
            v_reg <= v_next;
        end
    end

endmodule

@@ design/slab_cbrt.sv @@
module slab_cbrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0][slab_pkg::V_W-1:0]     in_v,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0][slab_pkg::R_W-1:0]     out_f
);

    localparam int R_W = slab_pkg::R_W;
    localparam int NS  = R_W + 1;
    localparam int LW  = slab_pkg::LIN2_W;

    typedef struct packed {
        logic [slab_pkg::V_W-1:0] v;
        logic [R_W-1:0]           y;
        logic [2*R_W-1:0]         y2;
        logic [3*R_W-1:0]         y3;
        logic [LW-1:0]            lin;
        logic                     big;
    } lane_t;

    logic [NS-1:0]         valid_reg;
    logic [NS-1:0]         stage_en;
    lane_t [2:0]           st_reg  [NS];
    lane_t [2:0]           st_next [NS];

    always_comb
    begin
        stage_en[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[NS-1];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            out_f[l] = st_reg[NS-1][l].y;
        end
    end

    // one root bit per stage, cube and square kept by shift and add
    always_comb
    begin
        lane_t       src;
        lane_t       nxt;
        logic [63:0] c2;
        logic [63:0] c3;
        logic [63:0] tgt;
        logic [47:0] prod;
        int          k;
        for (int s = 0; s < NS; s++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (s == 0)
                begin
                    src     = '0;
                    src.v   = in_v[l];
                end
                else
                begin
                    src = st_reg[s-1][l];
                end
                nxt  = src;
                c2   = '0;
                c3   = '0;
                tgt  = '0;
                prod = '0;
                k    = 0;
                if (s < R_W)
                begin
                    k   = R_W - 1 - s;
                    c2  = 64'(src.y2) + (64'(src.y) << (k + 1)) + (64'd1 << (2 * k));
                    c3  = 64'(src.y3) + (64'(src.y2) << (k + 1)) + (64'(src.y2) << k)
                        + (64'(src.y) << (2 * k + 1)) + (64'(src.y) << (2 * k))
                        + (64'd1 << (3 * k));
                    tgt = 64'(src.v) << 32;
                    if (c3 <= tgt)
                    begin
                        nxt.y  = src.y | (R_W'(1) << k);
                        nxt.y2 = c2[2*R_W-1:0];
                        nxt.y3 = c3[3*R_W-1:0];
                    end
                end
                if (s == 0)
                begin
                    nxt.big = 32'(src.v) > slab_pkg::LAB_EPS;
                    nxt.lin = LW'(src.v[9:0]) * LW'(slab_pkg::LIN_MUL) + LW'(slab_pkg::LIN_ADD);
                end
                if (s == 1)
                begin
                    prod    = 48'(src.lin) * 48'(slab_pkg::RECIP);
                    nxt.lin = LW'(prod >> slab_pkg::RECIP_SH);
                end
                if (s == NS - 1)
                begin
                    nxt.y = src.big ? src.y : R_W'(src.lin) + R_W'(slab_pkg::LAB_OFS);
                end
                st_next[s][l] = nxt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (stage_en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (stage_en[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    // root search never overshoots its target; the check watches lane 1 only
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NS-2] |->
            (64'(st_reg[NS-2][1].y3) <= (64'(st_reg[NS-2][1].v) << 32)))
        else $error("cube root overshoot");

endmodule

@@ design/slab_out.sv @@
module slab_out #(
    parameter int FRAC_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0][slab_pkg::R_W-1:0]     in_f,
    output logic                              out_valid,
    input  logic                              out_ready,
    output slab_pkg::lab_t                    out_lab
);

    localparam int NS       = 2;
    localparam int SH       = 16 - FRAC_BITS;
    localparam int HALF     = 1 << (SH - 1);
    localparam int LMAX_RAW = 100 << FRAC_BITS;
    localparam int LMAX     = (LMAX_RAW > 32767) ? 32767 : LMAX_RAW;

    typedef struct packed {
        logic signed [31:0] l_q;
        logic signed [31:0] a_q;
        logic signed [31:0] b_q;
    } acc_t;

    logic [NS-1:0]  valid_reg;
    logic [NS-1:0]  stage_en;
    acc_t           acc_reg, acc_next;
    slab_pkg::lab_t lab_reg, lab_next;

    always_comb
    begin
        stage_en[NS-1] = !valid_reg[NS-1] || out_ready;
        stage_en[0]    = !valid_reg[0] || stage_en[1];
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[NS-1];
    assign out_lab   = lab_reg;

    always_comb
    begin
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        fx = signed'(32'(in_f[0]));
        fy = signed'(32'(in_f[1]));
        fz = signed'(32'(in_f[2]));
        acc_next.l_q = fy * 32'sd116 - 32'sd1048576;
        acc_next.a_q = (fx - fy) * 32'sd500;
        acc_next.b_q = (fy - fz) * 32'sd200;
    end

    always_comb
    begin
        logic signed [31:0] wl;
        logic signed [31:0] wa;
        logic signed [31:0] wb;
        wl = (acc_reg.l_q + 32'(HALF)) >>> SH;
        wa = (acc_reg.a_q + 32'(HALF)) >>> SH;
        wb = (acc_reg.b_q + 32'(HALF)) >>> SH;
        if (wl < 0)
        begin
            lab_next.lightness = '0;
        end
        else if (wl > 32'(LMAX))
        begin
            lab_next.lightness = 15'(LMAX);
        end
        else
        begin
            lab_next.lightness = wl[14:0];
        end
        if (wa > 32'sd32767)
        begin
            lab_next.green_red = 16'sh7fff;
        end
        else if (wa < -32'sd32768)
        begin
            lab_next.green_red = 16'sh8000;
        end
        else
        begin
            lab_next.green_red = wa[15:0];
        end
        if (wb > 32'sd32767)
        begin
            lab_next.blue_yellow = 16'sh7fff;
        end
        else if (wb < -32'sd32768)
        begin
            lab_next.blue_yellow = 16'sh8000;
        end
        else
        begin
            lab_next.blue_yellow = wb[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (stage_en[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            acc_reg <= acc_next;
        end
        if (stage_en[1])
        begin
            lab_reg <= lab_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_lab.lightness) <= 32'(LMAX)))
        else $error("lightness above limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("pipeline blocked while output drains");

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && stage_en[1] && acc_reg.a_q >= 0) |=> out_lab.green_red >= 0)
        else $error("green_red sign flipped");

endmodule

@@ design/srgb_to_lab_pixel.sv @@
// sRGB to CIELAB (D65) pixel converter
// input channel: pixel_valid / pixel_ready with one pixel word (red, green, blue)
// output channel: lab_valid / lab_ready with one lab word (lightness, green_red,
// blue_yellow), each scaled by 2^FRAC_BITS, chroma saturated to 16 bits
// pipeline order from input accept to lab_valid: transfer table and matrix,
//   cube root (one root bit per stage plus final select), then scaling and
//   clamping
// throughput: one pixel per cycle while the output is not stalled; every stage holds a valid bit
// stall: when lab_ready is low the output word holds; upstream stages keep
// accepting until the empty stages ahead are filled, then pixel_ready drops
// reset: all valid bits clear, nothing is in flight, no clearing pass
module srgb_to_lab_pixel #(
    parameter int FRAC_BITS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_valid,
    output logic             pixel_ready,
    input  slab_pkg::pixel_t pixel,
    output logic             lab_valid,
    input  logic             lab_ready,
    output slab_pkg::lab_t   lab
);

    logic                              xyz_valid;
    logic                              xyz_ready;
    logic [2:0][slab_pkg::V_W-1:0]     xyz_v;
    logic                              f_valid;
    logic                              f_ready;
    logic [2:0][slab_pkg::R_W-1:0]     f_val;

    slab_xyz u_xyz (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel_valid),
        .in_ready  (pixel_ready),
        .in_pix    (pixel),
        .out_valid (xyz_valid),
        .out_ready (xyz_ready),
        .out_v     (xyz_v)
    );

    slab_cbrt u_cbrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (xyz_valid),
        .in_ready  (xyz_ready),
        .in_v      (xyz_v),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_f     (f_val)
    );

    slab_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_f      (f_val),
        .out_valid (lab_valid),
        .out_ready (lab_ready),
        .out_lab   (lab)
    );

endmodule
